@@ design/rpe_pkg.sv @@
package rpe_pkg;

    localparam int LEN_W     = 16;
    localparam int DUR_W     = 20;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam int QUEUE_DEPTH_DEF = 4;

    // code modes
    localparam logic [1:0] MODE_MANCHESTER = 2'd0;
    localparam logic [1:0] MODE_RCO        = 2'd1;
    localparam logic [1:0] MODE_TORMATIC   = 2'd2;
    localparam logic [1:0] MODE_WOFI       = 2'd3;

    // commands
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_SYMBOL  = 2'd1;
    localparam logic [1:0] CMD_END     = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    // symbols
    localparam logic [1:0] SYM_ZERO    = 2'd0;
    localparam logic [1:0] SYM_ONE     = 2'd1;
    localparam logic [1:0] SYM_SYNC_LO = 2'd2;
    localparam logic [1:0] SYM_SYNC_HI = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_GAP  = 2'd3;

    localparam logic [LEN_W-1:0] BIT_LENGTH_RST = 16'd1000;

    // reciprocal division: q = (x * floor(2^S / d)) >> S, then one correction step
    localparam int DIV_X_W   = 21;
    localparam int DIV_SHIFT = 24;
    localparam int MUL_W     = DIV_X_W + DIV_SHIFT;
    localparam logic [DIV_SHIFT-1:0] RECIP_3  = DIV_SHIFT'((1 << DIV_SHIFT) / 3);
    localparam logic [DIV_SHIFT-1:0] RECIP_19 = DIV_SHIFT'((1 << DIV_SHIFT) / 19);
    localparam logic [DIV_SHIFT-1:0] RECIP_27 = DIV_SHIFT'((1 << DIV_SHIFT) / 27);
    localparam logic [DIV_X_W-1:0] DIV_3  = 21'd3;
    localparam logic [DIV_X_W-1:0] DIV_19 = 21'd19;
    localparam logic [DIV_X_W-1:0] DIV_27 = 21'd27;

    // duration selectors
    typedef logic [3:0] t_dsel;
    localparam t_dsel DS_ZERO   = 4'd0;
    localparam t_dsel DS_SYNC   = 4'd1;
    localparam t_dsel DS_GAP    = 4'd2;
    localparam t_dsel DS_HALF   = 4'd3;
    localparam t_dsel DS_QTR    = 4'd4;
    localparam t_dsel DS_QTR3   = 4'd5;
    localparam t_dsel DS_THIRD  = 4'd6;
    localparam t_dsel DS_THIRD2 = 4'd7;
    localparam t_dsel DS_W5     = 4'd8;
    localparam t_dsel DS_W20    = 4'd9;

    // one classified input: up to three segments
    typedef struct packed {
        logic [1:0]  cnt;
        logic [2:0]  lvl;
        t_dsel [2:0] sel;
    } t_job;

    // durations derived from bit_length
    typedef struct packed {
        logic [LEN_W-1:0] half;
        logic [LEN_W-1:0] qtr;
        logic [LEN_W-1:0] qtr3;
        logic [LEN_W-1:0] third;
        logic [LEN_W-1:0] third2;
        logic [LEN_W-1:0] w5;
        logic [LEN_W-1:0] w20;
    } t_durs;

endpackage

@@ design/rpe_if.sv @@
interface rpe_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [1:0] symbol;
    logic       gap_after;

    modport source(output valid, command, symbol, gap_after, input ready);
    modport sink(input valid, command, symbol, gap_after, output ready);
endinterface

interface rpe_seg_if;
    logic                     valid;
    logic                     ready;
    logic                     level;
    logic [rpe_pkg::DUR_W-1:0] duration;
    logic                     last;

    modport source(output valid, level, duration, last, input ready);
    modport sink(input valid, level, duration, last, output ready);
endinterface

@@ design/rpe_front.sv @@
module rpe_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rpe_cmd_if.sink             i_cmd,
    input  logic [1:0]          i_code_mode,
    input  logic                i_q_ready,
    output logic                o_push,
    output rpe_pkg::t_job       o_job
);

    logic          r_cur_level;
    logic          n_cur_level;
    logic          accept;
    rpe_pkg::t_job job;

    always_comb begin
        job.cnt = 2'd0;
        job.lvl = 3'b000;
        job.sel = {3{rpe_pkg::DS_ZERO}};
        case (i_cmd.command)
            rpe_pkg::CMD_START: begin
                job.cnt    = 2'd1;
                job.sel[0] = (i_code_mode == rpe_pkg::MODE_WOFI) ? rpe_pkg::DS_GAP
                                                                 : rpe_pkg::DS_ZERO;
            end
            rpe_pkg::CMD_SYMBOL: begin
                case (i_code_mode)
                    rpe_pkg::MODE_MANCHESTER: begin
                        case (i_cmd.symbol)
                            rpe_pkg::SYM_SYNC_LO: begin
                                job.cnt    = 2'd1;
                                job.sel[0] = rpe_pkg::DS_SYNC;
                            end
                            rpe_pkg::SYM_SYNC_HI: begin
                                job.cnt    = 2'd1;
                                job.lvl    = 3'b001;
                                job.sel[0] = rpe_pkg::DS_SYNC;
                            end
                            rpe_pkg::SYM_ZERO: begin
                                job.cnt = 2'd2;
                                job.lvl = 3'b001;
                                job.sel = {rpe_pkg::DS_ZERO, rpe_pkg::DS_HALF,
                                           rpe_pkg::DS_HALF};
                            end
                            default: begin
                                job.cnt = 2'd2;
                                job.lvl = 3'b010;
                                job.sel = {rpe_pkg::DS_ZERO, rpe_pkg::DS_HALF,
                                           rpe_pkg::DS_HALF};
                            end
                        endcase
                    end
                    rpe_pkg::MODE_RCO: begin
                        if (i_cmd.symbol == rpe_pkg::SYM_ZERO) begin
                            job.cnt = 2'd2;
                            job.lvl = 3'b001;
                            job.sel = {rpe_pkg::DS_ZERO, rpe_pkg::DS_QTR3, rpe_pkg::DS_QTR};
                        end else if (i_cmd.symbol == rpe_pkg::SYM_ONE) begin
                            job.cnt = 2'd2;
                            job.lvl = 3'b001;
                            job.sel = {rpe_pkg::DS_ZERO, rpe_pkg::DS_QTR, rpe_pkg::DS_QTR3};
                        end
                    end
                    rpe_pkg::MODE_TORMATIC: begin
                        if (i_cmd.symbol == rpe_pkg::SYM_ZERO) begin
                            job.cnt = 2'd2;
                            job.lvl = 3'b001;
                            job.sel = {rpe_pkg::DS_ZERO, rpe_pkg::DS_THIRD2,
                                       rpe_pkg::DS_THIRD};
                        end else if (i_cmd.symbol == rpe_pkg::SYM_ONE) begin
                            job.cnt = 2'd3;
                            job.lvl = 3'b101;
                            job.sel = {rpe_pkg::DS_THIRD, rpe_pkg::DS_THIRD,
                                       rpe_pkg::DS_THIRD};
                        end
                    end
                    default: begin
                        if (i_cmd.symbol == rpe_pkg::SYM_ZERO) begin
                            job.cnt = 2'd2;
                            job.lvl = 3'b001;
                            job.sel = {rpe_pkg::DS_ZERO, rpe_pkg::DS_W20, rpe_pkg::DS_W5};
                        end else if (i_cmd.symbol == rpe_pkg::SYM_ONE) begin
                            job.cnt = 2'd2;
                            job.lvl = 3'b001;
                            job.sel = {rpe_pkg::DS_ZERO, rpe_pkg::DS_W5, rpe_pkg::DS_W20};
                        end
                    end
                endcase
            end
            rpe_pkg::CMD_END: begin
                if (i_code_mode == rpe_pkg::MODE_MANCHESTER) begin
                    // drive low first; a gap then holds that low level
                    job.cnt    = i_cmd.gap_after ? 2'd2 : 2'd1;
                    job.sel[1] = rpe_pkg::DS_GAP;
                end else if (i_cmd.gap_after) begin
                    job.cnt    = 2'd1;
                    job.lvl[0] = r_cur_level;
                    job.sel[0] = rpe_pkg::DS_GAP;
                end
            end
            default: begin
                job.cnt = 2'd0;
            end
        endcase
    end

    assign i_cmd.ready = i_q_ready;
    assign accept      = i_cmd.valid && i_q_ready;
    assign o_push      = accept && (job.cnt != 2'd0);
    assign o_job       = job;

    // track the level of the last segment queued
    always_comb begin
        n_cur_level = r_cur_level;
        if (o_push) begin
            n_cur_level = job.lvl[job.cnt - 2'd1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_level <= 1'b0;
        end else begin
            r_cur_level <= n_cur_level;
        end
    end

endmodule

@@ design/rpe_fifo.sv @@
module rpe_fifo #(
    parameter int DEPTH = rpe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rpe_pkg::t_job i_job,
    output logic          o_ready,
    output logic          o_valid,
    output rpe_pkg::t_job o_job,
    input  logic          i_pop
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rpe_pkg::t_job    r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr;
    logic [IDX_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] n_wr;
    logic [IDX_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + IDX_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + IDX_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ design/rpe_dur.sv @@
module rpe_dur (
    input  logic                       i_clk,
    input  logic [rpe_pkg::LEN_W-1:0]  i_bit_len,
    output rpe_pkg::t_durs             o_durs
);

    localparam int XW = rpe_pkg::DIV_X_W;
    localparam int MW = rpe_pkg::MUL_W;
    localparam int SH = rpe_pkg::DIV_SHIFT;

    logic [XW-1:0] x3;
    logic [XW-1:0] x19;
    logic [XW-1:0] x27;
    logic [MW-1:0] p3;
    logic [MW-1:0] p19;
    logic [MW-1:0] p27;

    logic [XW-1:0] r_x3;
    logic [XW-1:0] r_x19;
    logic [XW-1:0] r_x27;
    logic [XW-1:0] r_q3;
    logic [XW-1:0] r_q19;
    logic [XW-1:0] r_q27;
    logic [rpe_pkg::LEN_W-3:0] r_qtr;
    logic [rpe_pkg::LEN_W-2:0] r_half;

    logic [XW-1:0]  t3;
    rpe_pkg::t_durs r_durs;

    // the estimate is exact or one short: correct with one compare
    function automatic logic [XW-1:0] fix_q(input logic [XW-1:0] x,
                                            input logic [XW-1:0] q0,
                                            input logic [XW-1:0] d);
        logic [XW-1:0] rem;
        rem = x - q0 * d;
        fix_q = (rem >= d) ? q0 + XW'(1) : q0;
    endfunction

    assign x3  = XW'(i_bit_len);
    assign x19 = XW'({i_bit_len, 2'b00}) + XW'(i_bit_len);
    assign x27 = XW'({x19, 2'b00});
    assign p3  = MW'(x3)  * MW'(rpe_pkg::RECIP_3);
    assign p19 = MW'(x19) * MW'(rpe_pkg::RECIP_19);
    assign p27 = MW'(x27) * MW'(rpe_pkg::RECIP_27);

    always_ff @(posedge i_clk) begin
        r_x3   <= x3;
        r_x19  <= x19;
        r_x27  <= x27;
        r_q3   <= p3[SH +: XW];
        r_q19  <= p19[SH +: XW];
        r_q27  <= p27[SH +: XW];
        r_qtr  <= i_bit_len[rpe_pkg::LEN_W-1:2];
        r_half <= i_bit_len[rpe_pkg::LEN_W-1:1];
    end

    assign t3 = fix_q(r_x3, r_q3, rpe_pkg::DIV_3);

    always_ff @(posedge i_clk) begin
        r_durs.half   <= rpe_pkg::LEN_W'(r_half);
        r_durs.qtr    <= rpe_pkg::LEN_W'(r_qtr);
        r_durs.qtr3   <= rpe_pkg::LEN_W'(r_qtr) + rpe_pkg::LEN_W'({r_qtr, 1'b0});
        r_durs.third  <= rpe_pkg::LEN_W'(t3);
        r_durs.third2 <= rpe_pkg::LEN_W'({t3, 1'b0});
        r_durs.w5     <= rpe_pkg::LEN_W'(fix_q(r_x19, r_q19, rpe_pkg::DIV_19));
        r_durs.w20    <= rpe_pkg::LEN_W'(fix_q(r_x27, r_q27, rpe_pkg::DIV_27));
    end

    assign o_durs = r_durs;

endmodule

@@ design/rpe_back.sv @@
module rpe_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    input  rpe_pkg::t_job              i_job,
    output logic                       o_pop,
    input  rpe_pkg::t_durs             i_durs,
    input  logic [rpe_pkg::LEN_W-1:0]  i_sync,
    input  logic [rpe_pkg::DUR_W-1:0]  i_gap,
    rpe_seg_if.source                  o_seg
);

    logic                      r_valid;
    logic                      r_level;
    logic [rpe_pkg::DUR_W-1:0] r_dur;
    logic                      r_last;
    logic [1:0]                r_idx;
    logic                      n_valid;
    logic [1:0]                n_idx;

    logic                      advance;
    logic                      seg_last;
    rpe_pkg::t_dsel            sel;
    logic [rpe_pkg::DUR_W-1:0] dur;

    assign advance  = i_job_valid && (!r_valid || o_seg.ready);
    assign seg_last = (r_idx == i_job.cnt - 2'd1);
    assign o_pop    = advance && seg_last;
    assign sel      = i_job.sel[r_idx];

    always_comb begin
        case (sel)
            rpe_pkg::DS_ZERO:   dur = '0;
            rpe_pkg::DS_SYNC:   dur = rpe_pkg::DUR_W'(i_sync);
            rpe_pkg::DS_GAP:    dur = i_gap;
            rpe_pkg::DS_HALF:   dur = rpe_pkg::DUR_W'(i_durs.half);
            rpe_pkg::DS_QTR:    dur = rpe_pkg::DUR_W'(i_durs.qtr);
            rpe_pkg::DS_QTR3:   dur = rpe_pkg::DUR_W'(i_durs.qtr3);
            rpe_pkg::DS_THIRD:  dur = rpe_pkg::DUR_W'(i_durs.third);
            rpe_pkg::DS_THIRD2: dur = rpe_pkg::DUR_W'(i_durs.third2);
            rpe_pkg::DS_W5:     dur = rpe_pkg::DUR_W'(i_durs.w5);
            rpe_pkg::DS_W20:    dur = rpe_pkg::DUR_W'(i_durs.w20);
            default:            dur = '0;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (advance) begin
            n_valid = 1'b1;
            n_idx   = seg_last ? 2'd0 : r_idx + 2'd1;
        end else if (o_seg.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // load the next segment into the output register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_level <= i_job.lvl[r_idx];
            r_dur   <= dur;
            r_last  <= seg_last;
        end
    end

    assign o_seg.valid    = r_valid;
    assign o_seg.level    = r_level;
    assign o_seg.duration = r_dur;
    assign o_seg.last     = r_last;

`ifndef SYNTHESIS
    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> (r_idx < i_job.cnt))
        else $error("segment index past end of queued job");

    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> (i_job.cnt != 2'd0))
        else $error("queued job carries no segments");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_seg.ready && !advance) |=> !r_valid)
        else $error("output register kept a taken segment");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_job_valid |-> (r_idx == 2'd0))
        else $error("segment index left mid-job with empty queue");
`endif

endmodule

@@ design/rf_remote_pulse_encoder.sv @@
// A segment reaches the output through the queue and then the output register.
// Throughput: one segment per cycle while a job is queued and o_seg.ready is high;
// a command gives 0 to 3 segments; commands that give none skip the queue.
// A queue of QUEUE_DEPTH classified commands lets input and output stall independently;
// derived durations follow a bit_length write through the rpe_dur registers.
// Reset (sync, active low) empties queue and output, zeroes the pin level, loads defaults.
module rf_remote_pulse_encoder #(
    parameter int QUEUE_DEPTH = rpe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rpe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rpe_pkg::CFG_W-1:0]      i_cfg_data,
    rpe_cmd_if.sink                        i_cmd,
    rpe_seg_if.source                      o_seg
);

    logic [1:0]                r_code_mode;
    logic [rpe_pkg::LEN_W-1:0] r_bit_len;
    logic [rpe_pkg::LEN_W-1:0] r_sync_len;
    logic [rpe_pkg::DUR_W-1:0] r_repeat_gap;

    logic           q_ready;
    logic           q_push;
    rpe_pkg::t_job  push_job;
    logic           q_valid;
    rpe_pkg::t_job  head_job;
    logic           q_pop;
    rpe_pkg::t_durs durs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_mode  <= rpe_pkg::MODE_MANCHESTER;
            r_bit_len    <= rpe_pkg::BIT_LENGTH_RST;
            r_sync_len   <= '0;
            r_repeat_gap <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rpe_pkg::CFG_CODE_MODE:   r_code_mode  <= i_cfg_data[1:0];
                rpe_pkg::CFG_BIT_LENGTH:  r_bit_len    <= i_cfg_data[rpe_pkg::LEN_W-1:0];
                rpe_pkg::CFG_SYNC_LENGTH: r_sync_len   <= i_cfg_data[rpe_pkg::LEN_W-1:0];
                rpe_pkg::CFG_REPEAT_GAP:  r_repeat_gap <= i_cfg_data[rpe_pkg::DUR_W-1:0];
                default: ;
            endcase
        end
    end

    rpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_code_mode (r_code_mode),
        .i_q_ready   (q_ready),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    rpe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    rpe_dur u_dur (
        .i_clk     (i_clk),
        .i_bit_len (r_bit_len),
        .o_durs    (durs)
    );

    rpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .i_durs      (durs),
        .i_sync      (r_sync_len),
        .i_gap       (r_repeat_gap),
        .o_seg       (o_seg)
    );

endmodule
